@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files that check their own logic.
// No dependencies; include once per file that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Condition must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`endif

@@ rtl/ptcc_pkg.sv @@
// Package of the photon time-tag cross-correlator: codes, widths, defaults.
// No dependencies.
package ptcc_pkg;

  // Default sizes
  localparam int HIST_BINS_DEF    = 1024;
  localparam int WINDOW_DEPTH_DEF = 16;

  // Field widths
  localparam int CMD_W   = 2;
  localparam int WORD_W  = 32;
  localparam int BIDX_W  = 10;
  localparam int COUNT_W = 32;
  localparam int GTIME_W = 63;
  localparam int STAT_W  = 2;
  localparam int TAU_W   = 32;
  localparam int NBIN_W  = 11;
  localparam int CFGI_W  = 2;
  localparam int CFGD_W  = 32;
  localparam int TIME_W  = 31;
  localparam int LAP_W   = 32;

  // Commands
  localparam logic [CMD_W-1:0] CMD_EVENT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_IDX = 2'd2;

  // Register indexes
  localparam logic [CFGI_W-1:0] REG_TAU_MIN  = 2'd0;
  localparam logic [CFGI_W-1:0] REG_TAU_MAX  = 2'd1;
  localparam logic [CFGI_W-1:0] REG_NUM_BINS = 2'd2;

  // Register reset values
  localparam logic [TAU_W-1:0]  TAU_MIN_RST  = 32'd0;
  localparam logic [TAU_W-1:0]  TAU_MAX_RST  = 32'd1024;
  localparam logic [NBIN_W-1:0] NUM_BINS_RST = 11'd1024;

endpackage

@@ rtl/ptcc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptcc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/photon_timetag_cross_correlator.sv @@
// Top level of the photon time-tag cross-correlator.
// Depends on ptcc_pkg, ptcc_ram and assert_macros.svh.
`include "assert_macros.svh"

// Time-tag cross-correlator. An event item unwraps its time and is paired
// with every event held in the opposite channel's window; each of the two
// delays of a pair that falls in [tau_min, tau_max) is binned by a multiply
// and a bit-serial divide, then counted by a read-modify-write of the
// histogram RAM. A delay out of range skips the multiply, divide and
// histogram update. The bin divide gives one quotient bit per cycle,
// clog2(HIST_BINS+1) bits in all. A read item with an index out of range
// skips the histogram read, and an unused command goes straight to its
// result. After reset, and for every clear item, a sweep zeroes the
// histogram one bin per cycle while no item is taken. A stalled result
// holds the block until it leaves. Configuration must be written only
// while idle; the block itself does not enforce this.
module photon_timetag_cross_correlator #(
  parameter int HIST_BINS    = ptcc_pkg::HIST_BINS_DEF,
  parameter int WINDOW_DEPTH = ptcc_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ptcc_pkg::CFGI_W-1:0]    cfg_index,
  input  logic [ptcc_pkg::CFGD_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ptcc_pkg::CMD_W-1:0]     cmd,
  input  logic [ptcc_pkg::WORD_W-1:0]    raw_word,
  input  logic [ptcc_pkg::BIDX_W-1:0]    bin_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ptcc_pkg::COUNT_W-1:0]   bin_count,
  output logic [ptcc_pkg::GTIME_W-1:0]   global_time,
  output logic [ptcc_pkg::STAT_W-1:0]    status
);
  import ptcc_pkg::*;

  localparam int HW  = $clog2(HIST_BINS);
  localparam int EBW = $clog2(HIST_BINS + 1);
  localparam int KW  = $clog2(EBW + 1);
  localparam int PW  = TAU_W + EBW;
  localparam int WPW = $clog2(WINDOW_DEPTH);
  localparam int FW  = $clog2(WINDOW_DEPTH + 1);
  localparam int SW  = WPW + 2;
  localparam int DW  = GTIME_W + 1;

  // State codes
  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_RDWIN  = 4'd2;
  localparam logic [3:0] ST_DIFF   = 4'd3;
  localparam logic [3:0] ST_CHK    = 4'd4;
  localparam logic [3:0] ST_MUL    = 4'd5;
  localparam logic [3:0] ST_DIV    = 4'd6;
  localparam logic [3:0] ST_HRD    = 4'd7;
  localparam logic [3:0] ST_HWR    = 4'd8;
  localparam logic [3:0] ST_NEXT   = 4'd9;
  localparam logic [3:0] ST_APPEND = 4'd10;
  localparam logic [3:0] ST_RDHIST = 4'd11;
  localparam logic [3:0] ST_RDWAIT = 4'd12;
  localparam logic [3:0] ST_OUT    = 4'd13;

  // Configuration and derived values
  logic [TAU_W-1:0]  tau_min, tau_max;
  logic [NBIN_W-1:0] num_bins;
  logic [TAU_W-1:0]  span;
  logic              empty;
  logic [EBW-1:0]    eb;

  // Control state
  logic [3:0]        state;
  logic [HW-1:0]     clr_addr;
  logic              clr_reply;
  logic [TIME_W-1:0] prev_time;
  logic [LAP_W-1:0]  lap;
  logic [FW-1:0]     fill0, fill1, walk_n;
  logic [WPW-1:0]    head0, head1, rp;
  logic              dir;
  logic [KW-1:0]     kcnt;

  // Item and datapath registers
  logic               ch;
  logic [BIDX_W-1:0]  bidx;
  logic [GTIME_W-1:0] gtime;
  logic [DW-1:0]      diff;
  logic [TAU_W-1:0]   off;
  logic [PW-1:0]      rem, dv;
  logic [EBW-1:0]     quo;
  logic [COUNT_W-1:0] res_count;
  logic [GTIME_W-1:0] res_gtime;
  logic [STAT_W-1:0]  res_status;

  // Memory ports
  logic               h_we;
  logic [HW-1:0]      h_waddr, h_raddr;
  logic [COUNT_W-1:0] h_wdata, h_rdata;
  logic               w_we;
  logic [WPW:0]       w_waddr, w_raddr;
  logic [GTIME_W-1:0] w_rdata;

  // Combinational helpers
  logic [TIME_W-1:0]  ev_time;
  logic [LAP_W-1:0]   lap_next;
  logic [DW-1:0]      tmin_x, tmax_x;
  logic               in_rng;
  logic [FW-1:0]      own_fill;
  logic [WPW-1:0]     own_head;
  logic [SW-1:0]      pos_sum;
  logic [WPW-1:0]     pos;
  logic [WPW-1:0]     rp_inc, head_inc;
  logic               take_out;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tau_min  <= TAU_MIN_RST;
      tau_max  <= TAU_MAX_RST;
      num_bins <= NUM_BINS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TAU_MIN:  tau_min  <= cfg_data;
        REG_TAU_MAX:  tau_max  <= cfg_data;
        REG_NUM_BINS: num_bins <= cfg_data[NBIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Span, empty window and clamped bin count
  assign span  = tau_max - tau_min;
  assign empty = $signed(tau_max) <= $signed(tau_min);
  always_comb begin
    if (num_bins == '0) begin
      eb = EBW'(1);
    end else if (32'(num_bins) > 32'(HIST_BINS)) begin
      eb = EBW'(HIST_BINS);
    end else begin
      eb = EBW'(num_bins);
    end
  end

  // Helpers
  assign ev_time  = raw_word[TIME_W-1:0];
  assign lap_next = (ev_time < prev_time) ? lap + 1'b1 : lap;
  assign tmin_x   = {{(DW-TAU_W){tau_min[TAU_W-1]}}, tau_min};
  assign tmax_x   = {{(DW-TAU_W){tau_max[TAU_W-1]}}, tau_max};
  assign in_rng   = !empty && ($signed(diff) >= $signed(tmin_x))
                    && ($signed(diff) < $signed(tmax_x));
  assign own_fill = ch ? fill1 : fill0;
  assign own_head = ch ? head1 : head0;
  assign pos_sum  = SW'(own_head) + SW'(own_fill);
  assign pos      = (pos_sum >= SW'(WINDOW_DEPTH)) ?
                    WPW'(pos_sum - SW'(WINDOW_DEPTH)) : WPW'(pos_sum);
  assign rp_inc   = (rp == WPW'(WINDOW_DEPTH - 1)) ? '0 : rp + 1'b1;
  assign head_inc = (own_head == WPW'(WINDOW_DEPTH - 1)) ? '0 : own_head + 1'b1;
  assign in_stall = (state != ST_IDLE);
  assign take_out = !out_valid || !out_stall;

  // Histogram port selection
  always_comb begin
    h_we    = 1'b0;
    h_waddr = HW'(quo);
    h_wdata = (h_rdata == '1) ? h_rdata : h_rdata + 1'b1;
    h_raddr = HW'(quo);
    unique case (state)
      ST_CLEAR: begin
        h_we    = 1'b1;
        h_waddr = clr_addr;
        h_wdata = '0;
      end
      ST_HWR:   h_we = 1'b1;
      ST_RDHIST: h_raddr = HW'(bidx);
      default: ;
    endcase
  end

  // Window port selection
  assign w_we    = (state == ST_APPEND);
  assign w_waddr = {ch, pos};
  assign w_raddr = {~ch, rp};

  ptcc_ram #(.WIDTH(COUNT_W), .DEPTH(HIST_BINS)) u_hist (
    .clk  (clk),
    .we   (h_we),
    .waddr(h_waddr),
    .wdata(h_wdata),
    .raddr(h_raddr),
    .rdata(h_rdata)
  );

  ptcc_ram #(.WIDTH(GTIME_W), .DEPTH(2 * (1 << WPW))) u_win (
    .clk  (clk),
    .we   (w_we),
    .waddr(w_waddr),
    .wdata(gtime),
    .raddr(w_raddr),
    .rdata(w_rdata)
  );

  // Control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      clr_reply <= 1'b0;
      prev_time <= '0;
      lap       <= '0;
      fill0     <= '0;
      fill1     <= '0;
      head0     <= '0;
      head1     <= '0;
      walk_n    <= '0;
      rp        <= '0;
      dir       <= 1'b0;
      kcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_OUT && take_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (clr_addr == HW'(HIST_BINS - 1)) begin
            clr_addr <= '0;
            state    <= clr_reply ? ST_OUT : ST_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            unique case (cmd)
              CMD_EVENT: begin
                lap       <= lap_next;
                prev_time <= ev_time;
                dir       <= 1'b0;
                walk_n    <= raw_word[WORD_W-1] ? fill0 : fill1;
                rp        <= raw_word[WORD_W-1] ? head0 : head1;
                if ((raw_word[WORD_W-1] ? fill0 : fill1) == '0) begin
                  state <= ST_APPEND;
                end else begin
                  state <= ST_RDWIN;
                end
              end
              CMD_READ: begin
                if (32'(bin_index) >= 32'(eb)) begin
                  state <= ST_OUT;
                end else begin
                  state <= ST_RDHIST;
                end
              end
              CMD_CLEAR: begin
                fill0     <= '0;
                fill1     <= '0;
                clr_addr  <= '0;
                clr_reply <= 1'b1;
                state     <= ST_CLEAR;
              end
              default: state <= ST_OUT;
            endcase
          end
        end
        ST_RDWIN: state <= ST_DIFF;
        ST_DIFF:  state <= ST_CHK;
        ST_CHK:   state <= in_rng ? ST_MUL : ST_NEXT;
        ST_MUL: begin
          kcnt  <= KW'(EBW - 1);
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (kcnt == '0) begin
            state <= ST_HRD;
          end else begin
            kcnt <= kcnt - 1'b1;
          end
        end
        ST_HRD: state <= ST_HWR;
        ST_HWR: state <= ST_NEXT;
        ST_NEXT: begin
          if (!dir) begin
            dir   <= 1'b1;
            state <= ST_CHK;
          end else if (walk_n == FW'(1)) begin
            state <= ST_APPEND;
          end else begin
            walk_n <= walk_n - 1'b1;
            rp     <= rp_inc;
            dir    <= 1'b0;
            state  <= ST_RDWIN;
          end
        end
        ST_APPEND: begin
          if (own_fill == FW'(WINDOW_DEPTH)) begin
            if (ch) head1 <= head_inc;
            else    head0 <= head_inc;
          end else begin
            if (ch) fill1 <= fill1 + 1'b1;
            else    fill0 <= fill0 + 1'b1;
          end
          state <= ST_OUT;
        end
        ST_RDHIST: state <= ST_RDWAIT;
        ST_RDWAIT: state <= ST_OUT;
        ST_OUT: begin
          if (take_out) begin
            clr_reply <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath and result registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        ch         <= raw_word[WORD_W-1];
        bidx       <= bin_index;
        gtime      <= {lap_next, ev_time};
        res_count  <= '0;
        res_gtime  <= '0;
        res_status <= (cmd == CMD_READ && 32'(bin_index) >= 32'(eb)) ?
                      STAT_BAD_IDX : STAT_OK;
      end
      ST_DIFF: diff <= {1'b0, gtime} - {1'b0, w_rdata};
      ST_CHK:  off  <= diff[TAU_W-1:0] - tau_min;
      ST_MUL: begin
        rem <= PW'(off) * PW'(eb);
        dv  <= PW'(span) << (EBW - 1);
        quo <= '0;
      end
      // Restoring divide, one quotient bit per cycle
      ST_DIV: begin
        if (rem >= dv) begin
          rem <= rem - dv;
          quo <= {quo[EBW-2:0], 1'b1};
        end else begin
          quo <= {quo[EBW-2:0], 1'b0};
        end
        dv <= dv >> 1;
      end
      ST_NEXT: begin
        if (!dir) begin
          diff <= '0 - diff;
        end
      end
      ST_APPEND: begin
        res_gtime  <= gtime;
        res_status <= (own_fill == FW'(WINDOW_DEPTH)) ? STAT_FULL : STAT_OK;
      end
      ST_RDWAIT: res_count <= h_rdata;
      ST_OUT: begin
        if (take_out) begin
          bin_count   <= res_count;
          global_time <= res_gtime;
          status      <= res_status;
        end
      end
      default: ;
    endcase
  end

  // Checks
  `ASSERT_CLK(a_fill_bound, clk, rst, fill0 <= FW'(WINDOW_DEPTH) && fill1 <= FW'(WINDOW_DEPTH))
  `ASSERT_CLK(a_bin_below_count, clk, rst, state == ST_HRD |-> 32'(quo) < 32'(eb))
  `ASSERT_NEVER(a_inc_zero, clk, rst, state == ST_HWR && h_wdata == '0)

endmodule

@@ tb/photon_timetag_cross_correlator_tb.sv @@
// Self-checking bench for the photon time-tag cross-correlator.
// Depends on ptcc_pkg and photon_timetag_cross_correlator; a scoreboard class predicts.
module photon_timetag_cross_correlator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ptcc_pkg::*;

  localparam int NBINS = HIST_BINS_DEF;
  localparam int DEPTH = WINDOW_DEPTH_DEF;

  // Command code with no function
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [GTIME_W-1:0] gtime;
    logic [STAT_W-1:0]  stat;
  } corr_result_t;

  // Correlation predictor and store of expected results
  class corr_scoreboard;
    longint tmin, tmax;
    int unsigned nbins;
    bit [31:0] hist [NBINS];
    longint unsigned win0 [DEPTH], win1 [DEPTH];
    int unsigned fill0, fill1;
    bit [30:0] prev_t;
    bit [31:0] laps;
    corr_result_t pending [$];
    int errors;

    function void reset_state();
      tmin = 0; tmax = 1024; nbins = 1024;
      foreach (hist[i]) hist[i] = 0;
      fill0 = 0; fill1 = 0; prev_t = 0; laps = 0;
    endfunction

    function void write_reg(logic [CFGI_W-1:0] idx, logic [31:0] v);
      case (idx)
        REG_TAU_MIN:  tmin = longint'($signed(v));
        REG_TAU_MAX:  tmax = longint'($signed(v));
        REG_NUM_BINS: nbins = v[10:0];
        default: ;
      endcase
    endfunction

    function int unsigned used_bins();
      if (nbins == 0) return 1;
      if (nbins > NBINS) return NBINS;
      return nbins;
    endfunction

    // Count delay a - b if it falls in the delay window
    function void count_delay(longint unsigned a, longint unsigned b);
      longint d;
      longint unsigned mag, bidx;
      if (tmax <= tmin) return;
      mag = (a >= b) ? a - b : b - a;
      if (mag > 64'h1_0000_0000) return;
      d = (a >= b) ? longint'(mag) : -longint'(mag);
      if (d < tmin || d >= tmax) return;
      bidx = longint'(d - tmin) * used_bins() / longint'(tmax - tmin);
      if (bidx >= NBINS) return;
      if (hist[bidx] != 32'hffff_ffff) hist[bidx]++;
    endfunction

    function void note_item(logic [1:0] op, logic [31:0] word, logic [9:0] bidx);
      corr_result_t r;
      longint unsigned g;
      r = '0;
      if (op == CMD_EVENT) begin
        if (word[30:0] < prev_t) laps++;
        prev_t = word[30:0];
        g = {laps, word[30:0]};
        g[63] = 1'b0;
        r.gtime = g[62:0];
        if (!word[31]) begin
          for (int i = 0; i < fill1; i++) begin
            count_delay(g, win1[i]); count_delay(win1[i], g);
          end
          if (fill0 >= DEPTH) begin
            for (int i = 0; i < DEPTH - 1; i++) win0[i] = win0[i+1];
            win0[DEPTH-1] = g; r.stat = STAT_FULL;
          end else begin
            win0[fill0] = g; fill0++;
          end
        end else begin
          for (int i = 0; i < fill0; i++) begin
            count_delay(g, win0[i]); count_delay(win0[i], g);
          end
          if (fill1 >= DEPTH) begin
            for (int i = 0; i < DEPTH - 1; i++) win1[i] = win1[i+1];
            win1[DEPTH-1] = g; r.stat = STAT_FULL;
          end else begin
            win1[fill1] = g; fill1++;
          end
        end
      end else if (op == CMD_READ) begin
        if (bidx >= used_bins()) r.stat = STAT_BAD_IDX;
        else r.count = hist[bidx];
      end else if (op == CMD_CLEAR) begin
        foreach (hist[i]) hist[i] = 0;
        fill0 = 0; fill1 = 0;
      end
      pending.push_back(r);
    endfunction

    function void check_result(corr_result_t got);
      corr_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.count !== exp_r.count) begin
        $display("%0t: bin_count expected %h actual %h", $realtime, exp_r.count, got.count);
        errors++;
      end
      if (got.gtime !== exp_r.gtime) begin
        $display("%0t: global_time expected %h actual %h", $realtime, exp_r.gtime, got.gtime);
        errors++;
      end
      if (got.stat !== exp_r.stat) begin
        $display("%0t: status expected %h actual %h", $realtime, exp_r.stat, got.stat);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic cfg_we;
  logic [CFGI_W-1:0] cfg_index;
  logic [CFGD_W-1:0] cfg_data;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [CMD_W-1:0] cmd;
  logic [WORD_W-1:0] raw_word;
  logic [BIDX_W-1:0] bin_index;
  logic [COUNT_W-1:0] bin_count;
  logic [GTIME_W-1:0] global_time;
  logic [STAT_W-1:0] status;

  photon_timetag_cross_correlator uut (.*);

  corr_scoreboard sb;
  int send_idle_pct, stall_pct;
  bit hold_off;
  longint cycles;
  bit [30:0] tcur;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= hold_off || ($urandom_range(99) < stall_pct);
    if (!rst && out_valid && !out_stall)
      sb.check_result('{bin_count, global_time, status});
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > 10_000_000) begin
      $display("photon_timetag_cross_correlator regression: fail");
      $finish;
    end
  end

  // Valid stays high after the accepting edge until the next item or a drain
  task automatic send_item(logic [1:0] op, logic [31:0] word, logic [9:0] bidx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1; cmd <= op; raw_word <= word; bin_index <= bidx;
    do @(posedge clk); while (in_stall);
    sb.note_item(op, word, bidx);
  endtask

  task automatic write_reg(logic [CFGI_W-1:0] idx, logic [31:0] v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, v);
    @(posedge clk);
  endtask

  // Drain all results, then allow for a clear sweep or a long event
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  // Event with a random step of at most step_max; a small step lands delays in the window
  task automatic near_event(int unsigned step_max);
    logic [31:0] w;
    tcur = tcur + 31'($urandom_range(step_max));
    w = {1'($urandom_range(1)), tcur};
    send_item(CMD_EVENT, w, '0);
  endtask

  task automatic random_phase(int n, int unsigned step_max);
    int unsigned k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 70) near_event(step_max);
      else if (k < 90) send_item(CMD_READ, 0, 10'($urandom_range(1023)));
      else if (k < 93) send_item(CMD_CLEAR, $urandom, 10'($urandom));
      else if (k < 95) send_item(CMD_SPARE, $urandom, 10'($urandom));
      else send_item(CMD_EVENT, $urandom, 10'($urandom));
      if (k >= 95) tcur = raw_word[30:0];
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    sb.errors = 0;
    cycles = 0; hold_off = 0; tcur = 0;
    send_idle_pct = 0; stall_pct = 0;
    rst = 1; cfg_we = 0; cfg_index = '0; cfg_data = '0;
    in_valid = 0; cmd = '0; raw_word = '0; bin_index = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, each command, wrap, full window, bad index
    send_item(CMD_READ, 0, 10'd0);
    send_item(CMD_READ, 0, 10'd1023);
    send_item(CMD_EVENT, 32'h0000_0000, '0);
    send_item(CMD_EVENT, 32'h8000_0005, '0);
    send_item(CMD_EVENT, 32'h7fff_ffff, '0);
    send_item(CMD_EVENT, 32'hffff_ffff, '0);
    send_item(CMD_EVENT, 32'h0000_0010, '0);
    send_item(CMD_READ, 0, 10'd5);
    send_item(CMD_SPARE, 32'hffff_ffff, 10'h3ff);
    for (int i = 0; i < 18; i++) send_item(CMD_EVENT, 32'h0000_0020 + i, '0);
    send_item(CMD_READ, 0, 10'd1);
    send_item(CMD_CLEAR, 0, '0);
    drain();
    write_reg(REG_NUM_BINS, 32'd0);
    send_item(CMD_READ, 0, 10'd1);
    drain();

    // Random phases over several settings and idle patterns
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 51; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 51; end
        default: begin send_idle_pct = 14; stall_pct = 14; end
      endcase
      case (ph)
        0: begin write_reg(REG_TAU_MIN, 0); write_reg(REG_TAU_MAX, 1024);
                 write_reg(REG_NUM_BINS, 1024); end
        1: begin write_reg(REG_TAU_MIN, -500); write_reg(REG_TAU_MAX, 500);
                 write_reg(REG_NUM_BINS, 7); end
        2: begin write_reg(REG_TAU_MIN, 32'h8000_0000); write_reg(REG_TAU_MAX, 32'h7fff_ffff);
                 write_reg(REG_NUM_BINS, 2047); end
        3: begin write_reg(REG_TAU_MIN, 100); write_reg(REG_TAU_MAX, 100);
                 write_reg(REG_NUM_BINS, 1); end
        4: begin write_reg(REG_TAU_MIN, -3); write_reg(REG_TAU_MAX, 29);
                 write_reg(REG_NUM_BINS, 1000); end
        5: begin write_reg(REG_TAU_MIN, 32'h8000_0000); write_reg(REG_TAU_MAX, 0);
                 write_reg(REG_NUM_BINS, 64); end
        6: begin write_reg(REG_TAU_MIN, 0); write_reg(REG_TAU_MAX, 32'h7fff_ffff);
                 write_reg(REG_NUM_BINS, 1023); end
        default: begin write_reg(REG_TAU_MIN, -200); write_reg(REG_TAU_MAX, 300);
                 write_reg(REG_NUM_BINS, 1024); end
      endcase
      if (ph == 2) begin
        // Long receiver hold-off while items keep coming
        fork
          begin hold_off = 1; repeat (3000) @(posedge clk); hold_off = 0; end
          random_phase(60, 40);
        join
        random_phase(120, 40);
      end else begin
        random_phase(180, (ph == 6) ? 32'h7fff_ffff : 60);
      end
    end

    drain();
    if (sb.errors == 0) $display("photon_timetag_cross_correlator regression: pass");
    else $display("photon_timetag_cross_correlator regression: fail");
    $finish;
  end
endmodule
